// File: rtl/core/bblru_pkg.sv
// shared constants and types for the byte budget lru cache manager
// no dependencies; used by byte_budget_lru_cache_manager
package bblru_pkg;

    localparam int ENTRIES_DEFAULT  = 16;
    localparam int KEY_BITS_DEFAULT = 32;

    // capacity after reset: 64 MiB
    localparam logic [31:0] CAP_RESET = 32'd67108864;

    // request codes
    localparam logic [2:0] MODE_GET      = 3'd0;
    localparam logic [2:0] MODE_PUT      = 3'd1;
    localparam logic [2:0] MODE_REMOVE   = 3'd2;
    localparam logic [2:0] MODE_CONTAINS = 3'd3;
    localparam logic [2:0] MODE_CLEAR    = 3'd4;
    localparam logic [2:0] MODE_RSTAT    = 3'd5;
    localparam logic [2:0] MODE_TRIM     = 3'd6;

    // sequencer states
    typedef enum logic [4:0]
    {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_FREE  = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

endpackage

// File: rtl/core/bblru_ram.sv
// generic single write port ram with registered read
// no dependencies
module bblru_ram
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/byte_budget_lru_cache_manager.sv
// lru tag and recency manager bounded by a byte budget
// depends on bblru_pkg and bblru_ram (key and size store)
//
// channel | signals                                  | direction
// --------+------------------------------------------+----------
// in      | in_valid, in_ready, mode, item_key, size | request
// out     | out_valid, out_ready, hit .. evict total | result
// cfg     | cfg_valid, cfg_ready, capacity_bytes     | register
//
// a key lookup walks the key/size ram one entry a cycle; each lru eviction
//   is a pass through the check state and a further walk of the ram; a put
//   then scans for the lowest free slot
// clear, reset stats and mode 7 go from idle straight to the finish state
// reset clears valid bits, ranks, byte total and counters at once; no sweep
// in_ready is high only between requests; a result waiting in the output
//   register does not stop the next request, only its completion
module byte_budget_lru_cache_manager
#(
    parameter int ENTRIES  = bblru_pkg::ENTRIES_DEFAULT,
    parameter int KEY_BITS = bblru_pkg::KEY_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  mode,
    input  logic [31:0] item_key,
    input  logic [31:0] item_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        hit,
    output logic        accepted,
    output logic [3:0]  slot_index,
    output logic [31:0] entry_bytes,
    output logic [4:0]  evicted_now,
    output logic [31:0] total_bytes,
    output logic [4:0]  valid_entries,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] eviction_total,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] capacity_bytes
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = KEY_BITS + 32;

    bblru_pkg::state_t state_reg, state_next;

    logic [31:0]       cap_reg;
    logic [2:0]        mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [31:0]       size_reg, size_next;
    logic              evict_walk_reg, evict_walk_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;

    logic              valid_reg [ENTRIES];
    logic              valid_next [ENTRIES];
    logic [IW-1:0]     rank_reg [ENTRIES];
    logic [IW-1:0]     rank_next [ENTRIES];
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [31:0]       bytes_reg, bytes_next;
    logic [31:0]       hits_reg, hits_next;
    logic [31:0]       miss_reg, miss_next;
    logic [31:0]       evc_reg, evc_next;

    // per request results
    logic              op_hit_reg, op_hit_next;
    logic              op_acc_reg, op_acc_next;
    logic [IW-1:0]     op_slot_reg, op_slot_next;
    logic [31:0]       op_ebytes_reg, op_ebytes_next;
    logic [CW-1:0]     op_evict_reg, op_evict_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              o_hit_reg, o_hit_next;
    logic              o_acc_reg, o_acc_next;
    logic [3:0]        o_slot_reg, o_slot_next;
    logic [31:0]       o_ebytes_reg, o_ebytes_next;
    logic [4:0]        o_evict_reg, o_evict_next;
    logic [31:0]       o_total_reg, o_total_next;
    logic [4:0]        o_count_reg, o_count_next;
    logic [31:0]       o_hits_reg, o_hits_next;
    logic [31:0]       o_miss_reg, o_miss_next;
    logic [31:0]       o_evc_reg, o_evc_next;

    // ram port signals
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic [DW-1:0]     ram_wdata;
    logic              ram_re;
    logic [DW-1:0]     ram_rdata;
    logic [KEY_BITS-1:0] rd_key;
    logic [31:0]       rd_size;
    logic [IW-1:0]     rank_s;
    logic              match;
    logic              over;
    logic              is_put;

    bblru_ram
    #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    )
    u_store
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[DW-1:32];
    assign rd_size = ram_rdata[31:0];
    assign rank_s  = rank_reg[chk_idx_reg];
    assign is_put  = (mode_reg == bblru_pkg::MODE_PUT);

    // entry under test matches the walk's goal
    assign match = valid_reg[chk_idx_reg] &&
                   (evict_walk_reg ? (rank_s == IW'(cnt_reg - CW'(1)))
                                   : (rd_key == key_reg));

    // budget exceeded: with the incoming item for put, alone for trim
    assign over = is_put ? (({1'b0, bytes_reg} + {1'b0, size_reg}) > {1'b0, cap_reg})
                         : (bytes_reg > cap_reg);

    assign in_ready  = (state_reg == bblru_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer and state update
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        evict_walk_next = evict_walk_reg;
        rd_idx_next     = rd_idx_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        free_idx_next   = free_idx_reg;
        valid_next      = valid_reg;
        rank_next       = rank_reg;
        cnt_next        = cnt_reg;
        bytes_next      = bytes_reg;
        hits_next       = hits_reg;
        miss_next       = miss_reg;
        evc_next        = evc_reg;
        op_hit_next     = op_hit_reg;
        op_acc_next     = op_acc_reg;
        op_slot_next    = op_slot_reg;
        op_ebytes_next  = op_ebytes_reg;
        op_evict_next   = op_evict_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        o_hit_next      = o_hit_reg;
        o_acc_next      = o_acc_reg;
        o_slot_next     = o_slot_reg;
        o_ebytes_next   = o_ebytes_reg;
        o_evict_next    = o_evict_reg;
        o_total_next    = o_total_reg;
        o_count_next    = o_count_reg;
        o_hits_next     = o_hits_reg;
        o_miss_next     = o_miss_reg;
        o_evc_next      = o_evc_reg;
        ram_we          = 1'b0;
        ram_waddr       = free_idx_reg;
        ram_wdata       = {key_reg, size_reg};
        ram_re          = 1'b0;

        case (state_reg)
            bblru_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    key_next        = KEY_BITS'(item_key);
                    size_next       = item_size;
                    op_hit_next     = 1'b0;
                    op_acc_next     = 1'b0;
                    op_slot_next    = '0;
                    op_ebytes_next  = '0;
                    op_evict_next   = '0;
                    evict_walk_next = 1'b0;
                    rd_idx_next     = '0;
                    case (mode)
                        bblru_pkg::MODE_GET,
                        bblru_pkg::MODE_REMOVE,
                        bblru_pkg::MODE_CONTAINS:
                        begin
                            state_next = bblru_pkg::ST_WALK;
                        end
                        bblru_pkg::MODE_PUT:
                        begin
                            if (item_size > cap_reg)
                            begin
                                state_next = bblru_pkg::ST_FIN;
                            end
                            else
                            begin
                                state_next = bblru_pkg::ST_WALK;
                            end
                        end
                        bblru_pkg::MODE_CLEAR:
                        begin
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                valid_next[i] = 1'b0;
                                rank_next[i]  = '0;
                            end
                            cnt_next   = '0;
                            bytes_next = '0;
                            state_next = bblru_pkg::ST_FIN;
                        end
                        bblru_pkg::MODE_RSTAT:
                        begin
                            hits_next  = '0;
                            miss_next  = '0;
                            evc_next   = '0;
                            state_next = bblru_pkg::ST_FIN;
                        end
                        bblru_pkg::MODE_TRIM:
                        begin
                            state_next = bblru_pkg::ST_CHECK;
                        end
                        default:
                        begin
                            state_next = bblru_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            bblru_pkg::ST_WALK:
            begin
                // issue the next read while testing the previous one
                if (rd_idx_reg < CW'(ENTRIES))
                begin
                    ram_re       = 1'b1;
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_idx_reg[IW-1:0];
                end
                if (chk_vld_reg && match)
                begin
                    chk_vld_next = 1'b0;
                    if (evict_walk_reg || mode_reg == bblru_pkg::MODE_REMOVE || is_put)
                    begin
                        // drop the slot and close the rank gap
                        for (int i = 0; i < ENTRIES; i++)
                        begin
                            if (valid_reg[i] && rank_reg[i] > rank_s)
                            begin
                                rank_next[i] = rank_reg[i] - IW'(1);
                            end
                        end
                        valid_next[chk_idx_reg] = 1'b0;
                        rank_next[chk_idx_reg]  = '0;
                        bytes_next = bytes_reg - rd_size;
                        cnt_next   = cnt_reg - CW'(1);
                    end
                    if (evict_walk_reg)
                    begin
                        op_evict_next = op_evict_reg + CW'(1);
                        evc_next      = (&evc_reg) ? evc_reg : evc_reg + 32'd1;
                        state_next    = bblru_pkg::ST_CHECK;
                    end
                    else if (is_put)
                    begin
                        state_next = bblru_pkg::ST_CHECK;
                    end
                    else
                    begin
                        op_hit_next  = 1'b1;
                        op_slot_next = chk_idx_reg;
                        if (mode_reg == bblru_pkg::MODE_GET)
                        begin
                            // promote to most recent
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                if (valid_reg[i] && rank_reg[i] < rank_s)
                                begin
                                    rank_next[i] = rank_reg[i] + IW'(1);
                                end
                            end
                            rank_next[chk_idx_reg] = '0;
                            op_ebytes_next = rd_size;
                            hits_next = (&hits_reg) ? hits_reg : hits_reg + 32'd1;
                        end
                        state_next = bblru_pkg::ST_FIN;
                    end
                end
                else if (chk_vld_reg && chk_idx_reg == IW'(ENTRIES - 1))
                begin
                    // walk ended without a match
                    chk_vld_next = 1'b0;
                    if (evict_walk_reg || is_put)
                    begin
                        state_next = bblru_pkg::ST_CHECK;
                    end
                    else
                    begin
                        if (mode_reg == bblru_pkg::MODE_GET)
                        begin
                            miss_next = (&miss_reg) ? miss_reg : miss_reg + 32'd1;
                        end
                        state_next = bblru_pkg::ST_FIN;
                    end
                end
            end

            bblru_pkg::ST_CHECK:
            begin
                rd_idx_next   = '0;
                free_idx_next = '0;
                if (cnt_reg != '0 && (over || (is_put && cnt_reg == CW'(ENTRIES))))
                begin
                    evict_walk_next = 1'b1;
                    state_next      = bblru_pkg::ST_WALK;
                end
                else if (is_put)
                begin
                    state_next = bblru_pkg::ST_FREE;
                end
                else
                begin
                    state_next = bblru_pkg::ST_FIN;
                end
            end

            bblru_pkg::ST_FREE:
            begin
                if (!valid_reg[free_idx_reg])
                begin
                    // place the item as most recent in the lowest free slot
                    ram_we = 1'b1;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_reg[i])
                        begin
                            rank_next[i] = rank_reg[i] + IW'(1);
                        end
                    end
                    valid_next[free_idx_reg] = 1'b1;
                    rank_next[free_idx_reg]  = '0;
                    bytes_next   = bytes_reg + size_reg;
                    cnt_next     = cnt_reg + CW'(1);
                    op_acc_next  = 1'b1;
                    op_slot_next = free_idx_reg;
                    state_next   = bblru_pkg::ST_FIN;
                end
                else
                begin
                    free_idx_next = free_idx_reg + IW'(1);
                end
            end

            bblru_pkg::ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    o_hit_next     = op_hit_reg;
                    o_acc_next     = op_acc_reg;
                    o_slot_next    = 4'(op_slot_reg);
                    o_ebytes_next  = op_ebytes_reg;
                    o_evict_next   = 5'(op_evict_reg);
                    o_total_next   = bytes_reg;
                    o_count_next   = 5'(cnt_reg);
                    o_hits_next    = hits_reg;
                    o_miss_next    = miss_reg;
                    o_evc_next     = evc_reg;
                    state_next     = bblru_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = bblru_pkg::ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bblru_pkg::ST_IDLE;
            cap_reg       <= bblru_pkg::CAP_RESET;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            bytes_reg     <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            evc_reg       <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                valid_reg[i] <= 1'b0;
                rank_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            bytes_reg     <= bytes_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            evc_reg       <= evc_next;
            valid_reg     <= valid_next;
            rank_reg      <= rank_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= capacity_bytes;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        evict_walk_reg <= evict_walk_next;
        rd_idx_reg     <= rd_idx_next;
        chk_idx_reg    <= chk_idx_next;
        free_idx_reg   <= free_idx_next;
        op_hit_reg     <= op_hit_next;
        op_acc_reg     <= op_acc_next;
        op_slot_reg    <= op_slot_next;
        op_ebytes_reg  <= op_ebytes_next;
        op_evict_reg   <= op_evict_next;
        o_hit_reg      <= o_hit_next;
        o_acc_reg      <= o_acc_next;
        o_slot_reg     <= o_slot_next;
        o_ebytes_reg   <= o_ebytes_next;
        o_evict_reg    <= o_evict_next;
        o_total_reg    <= o_total_next;
        o_count_reg    <= o_count_next;
        o_hits_reg     <= o_hits_next;
        o_miss_reg     <= o_miss_next;
        o_evc_reg      <= o_evc_next;
    end

    assign out_valid      = out_valid_reg;
    assign hit            = o_hit_reg;
    assign accepted       = o_acc_reg;
    assign slot_index     = o_slot_reg;
    assign entry_bytes    = o_ebytes_reg;
    assign evicted_now    = o_evict_reg;
    assign total_bytes    = o_total_reg;
    assign valid_entries  = o_count_reg;
    assign hit_total      = o_hits_reg;
    assign miss_total     = o_miss_reg;
    assign eviction_total = o_evc_reg;

    // entry count never exceeds the table
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(ENTRIES))
        else $error("entry count above table size");

    // a lru walk always finds the oldest entry
    a_evict_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bblru_pkg::ST_WALK && evict_walk_reg && chk_vld_reg &&
         chk_idx_reg == IW'(ENTRIES - 1)) |-> match)
        else $error("lru walk found no oldest entry");

    // a placed slot is valid afterwards
    a_place: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bblru_pkg::ST_FREE && !valid_reg[free_idx_reg])
        |=> valid_reg[$past(free_idx_reg)])
        else $error("placed slot not valid");

    // the store is only written while placing an item
    a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> $past(state_reg) == bblru_pkg::ST_FREE && state_reg == bblru_pkg::ST_FIN)
        else $error("store written outside placement");

endmodule
